@@ hdl/lcasr_pkg.sv @@
package lcasr_pkg;

  localparam int DataBits = 24;
  localparam int OutBits = 24;
  localparam int PulseW = $clog2(DataBits + 4);
  localparam int TickW = 24;
  localparam int SettleW = 16;
  localparam int ChanW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;

  localparam logic [ChanW-1:0] ChanMax = 2'd2;
  localparam logic [ChanW-1:0] ChanUnknown = 2'd3;

  localparam logic [ChanW-1:0] NextChanReset = 2'd0;
  localparam logic [TickW-1:0] TimeoutReset = 24'd100000;
  localparam logic [SettleW-1:0] SettleReset = 16'd60;

  localparam logic [CfgIdxW-1:0] CfgNextChannel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSettleTicks = 2'd2;

  typedef enum logic [1:0] {
    PhWait = 2'd0,
    PhShift = 2'd1,
    PhSettle = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ChanW-1:0] next_channel;
    logic [TickW-1:0] timeout_ticks;
    logic [SettleW-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic clock_line;
    logic sample_valid;
    logic signed [OutBits-1:0] sample_value;
    logic [ChanW-1:0] sample_channel;
    logic timed_out;
  } result_t;

endpackage

@@ hdl/load_cell_adc_serial_reader.sv @@
// Serial reader for a two-wire 24-bit load-cell converter.
// Input channel: one request per time-base tick, carrying the sampled
// converter data line (in_valid_i / in_stall_o / data_line_i).
// Output channel: one result per request, carrying the clock line level to
// drive for that tick, an optional sign-extended sample with its channel,
// and a timeout flag (out_valid_o / out_stall_i).
// Throughput: one request per cycle while the receiver does not stall the
// output; the whole tick update is one pass of logic from the state registers
// into the output register. The result of a request is registered and shown
// in the cycle after it is accepted. When the receiver stalls, the result is
// held in the output register and in_stall_o rises, so no further request is
// taken until it drains. Reset: waits for data ready with the clock low,
// channel unknown (the first read reports nothing), registers at next_channel
// 0, timeout_ticks 100000, settle_ticks 60. The user must write registers
// through cfg_we_i at index cfg_index_i while the block is idle (the block
// has no check for it); a next_channel write takes effect at the next read.
module load_cell_adc_serial_reader (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic data_line_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic clock_line_o,
  output logic sample_valid_o,
  output logic signed [lcasr_pkg::OutBits-1:0] sample_value_o,
  output logic [lcasr_pkg::ChanW-1:0] sample_channel_o,
  output logic timed_out_o,
  input  logic cfg_we_i,
  input  logic [lcasr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcasr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  lcasr_pkg::cfg_t cfg_q;
  lcasr_pkg::result_t step_res;
  lcasr_pkg::result_t res_q;
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.next_channel <= lcasr_pkg::NextChanReset;
      cfg_q.timeout_ticks <= lcasr_pkg::TimeoutReset;
      cfg_q.settle_ticks <= lcasr_pkg::SettleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcasr_pkg::CfgNextChannel: begin
          cfg_q.next_channel <= cfg_wdata_i[lcasr_pkg::ChanW-1:0];
        end
        lcasr_pkg::CfgTimeoutTicks: begin
          cfg_q.timeout_ticks <= cfg_wdata_i[lcasr_pkg::TickW-1:0];
        end
        lcasr_pkg::CfgSettleTicks: begin
          cfg_q.settle_ticks <= cfg_wdata_i[lcasr_pkg::SettleW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lcasr_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .data_line_i (data_line_i),
    .cfg_i       (cfg_q),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clock_line_o = res_q.clock_line;
  assign sample_valid_o = res_q.sample_valid;
  assign sample_value_o = res_q.sample_value;
  assign sample_channel_o = res_q.sample_channel;
  assign timed_out_o = res_q.timed_out;

endmodule

@@ hdl/lcasr_fsm.sv @@
module lcasr_fsm (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic data_line_i,
  input  lcasr_pkg::cfg_t cfg_i,
  output lcasr_pkg::result_t result_o
);

  lcasr_pkg::phase_e phase_q, phase_d;
  logic [lcasr_pkg::TickW-1:0] tick_q, tick_d;
  logic [lcasr_pkg::PulseW-1:0] pulse_q, pulse_d;
  logic [lcasr_pkg::DataBits-1:0] shift_q, shift_d;
  logic [lcasr_pkg::ChanW-1:0] cur_chan_q, cur_chan_d;
  logic [lcasr_pkg::ChanW-1:0] latched_q, latched_d;

  logic [lcasr_pkg::TickW-1:0] tick_inc;
  logic [lcasr_pkg::PulseW-1:0] pulse_inc;
  logic [lcasr_pkg::PulseW-1:0] pulse_total;
  logic pulse_done;
  logic settle_done;
  logic timeout_hit;
  logic settle_zero;
  logic [lcasr_pkg::DataBits+lcasr_pkg::OutBits-1:0] word_ext;

  assign tick_inc = tick_q + 1'b1;
  assign pulse_inc = pulse_q + 1'b1;
  assign pulse_total = lcasr_pkg::PulseW'(lcasr_pkg::DataBits + 1)
                       + lcasr_pkg::PulseW'(latched_q);
  assign pulse_done = pulse_inc >= pulse_total;
  assign settle_zero = cfg_i.settle_ticks == '0;
  assign settle_done = tick_inc >= lcasr_pkg::TickW'(cfg_i.settle_ticks);
  assign timeout_hit = tick_inc >= cfg_i.timeout_ticks;
  assign word_ext = {{lcasr_pkg::OutBits{shift_q[lcasr_pkg::DataBits-1]}}, shift_q};

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      lcasr_pkg::PhShift: begin
        if (tick_q != '0 && pulse_done) begin
          phase_d = settle_zero ? lcasr_pkg::PhWait : lcasr_pkg::PhSettle;
        end
      end
      lcasr_pkg::PhSettle: begin
        if (settle_done) begin
          phase_d = lcasr_pkg::PhWait;
        end
      end
      default: begin
        phase_d = data_line_i ? lcasr_pkg::PhWait : lcasr_pkg::PhShift;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    logic finish;
    finish = 1'b0;
    tick_d = tick_q;
    pulse_d = pulse_q;
    shift_d = shift_q;
    cur_chan_d = cur_chan_q;
    latched_d = latched_q;
    result_o = '0;
    case (phase_q)
      lcasr_pkg::PhShift: begin
        if (tick_q == '0) begin
          result_o.clock_line = 1'b1;
          if (pulse_q < lcasr_pkg::PulseW'(lcasr_pkg::DataBits)) begin
            shift_d = {shift_q[lcasr_pkg::DataBits-2:0], data_line_i};
          end
          tick_d = lcasr_pkg::TickW'(1);
        end else begin
          tick_d = '0;
          pulse_d = pulse_inc;
          finish = pulse_done && settle_zero;
        end
      end
      lcasr_pkg::PhSettle: begin
        tick_d = tick_inc;
        finish = settle_done;
      end
      default: begin
        if (!data_line_i) begin
          tick_d = '0;
          pulse_d = '0;
          shift_d = '0;
          latched_d = (cfg_i.next_channel > lcasr_pkg::ChanMax) ? lcasr_pkg::ChanMax
                                                                 : cfg_i.next_channel;
        end else begin
          tick_d = tick_inc;
          if (timeout_hit) begin
            result_o.timed_out = 1'b1;
            tick_d = '0;
          end
        end
      end
    endcase
    if (finish) begin
      // all-ones word is dropped, unknown channel reports nothing
      if (!(&shift_q) && cur_chan_q <= lcasr_pkg::ChanMax) begin
        result_o.sample_valid = 1'b1;
        result_o.sample_value = word_ext[lcasr_pkg::OutBits-1:0];
        result_o.sample_channel = cur_chan_q;
      end
      cur_chan_d = latched_q;
      tick_d = '0;
      pulse_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lcasr_pkg::PhWait;
      tick_q <= '0;
      pulse_q <= '0;
      shift_q <= '0;
      cur_chan_q <= lcasr_pkg::ChanUnknown;
      latched_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q <= tick_d;
      pulse_q <= pulse_d;
      shift_q <= shift_d;
      cur_chan_q <= cur_chan_d;
      latched_q <= latched_d;
    end
  end

endmodule

@@ hdl/lcasr_checker.sv @@
module lcasr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic data_line_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic clock_line_o,
  input logic sample_valid_o,
  input logic signed [lcasr_pkg::OutBits-1:0] sample_value_o,
  input logic [lcasr_pkg::ChanW-1:0] sample_channel_o,
  input logic timed_out_o,
  input logic cfg_we_i,
  input logic [lcasr_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [lcasr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clock_line_o)
      && $stable(sample_valid_o) && $stable(sample_value_o)
      && $stable(sample_channel_o) && $stable(timed_out_o))
    else $error("stalled result changed");

  // empty output register never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // samples complete only on a low clock tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> !clock_line_o && !timed_out_o
      && sample_channel_o <= lcasr_pkg::ChanMax)
    else $error("bad sample result");

  // timeout only while waiting with clock low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timed_out_o |-> !clock_line_o)
    else $error("timeout with clock high");

endmodule

bind load_cell_adc_serial_reader lcasr_checker u_lcasr_checker (.*);
